// ===== rtl/pls_pkg.sv =====
`default_nettype none
package pls_pkg;

    // List geometry.
    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);

    // Field widths of the request and response.
    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_PREV   = 3'd5,
        CMD_NEXT   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_PICK
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    // Broadcast to every cell at the edge that takes a request.
    typedef struct packed {
        logic                  capture;
        logic [WORD_WIDTH-1:0] value;
        logic [IDX_W-1:0]      target;
        logic [CNT_W-1:0]      count;
    } cell_cap_t;

    // Broadcast to every cell at the edge that completes a request.
    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      k;
        logic [WORD_WIDTH-1:0] word;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/pls_req_if.sv =====
`default_nettype none
interface pls_req_if;
    logic                       valid;
    logic                       ready;
    logic [pls_pkg::CMD_W-1:0]  command;
    logic [pls_pkg::POS_W-1:0]  position;
    logic [pls_pkg::DATA_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/pls_rsp_if.sv =====
`default_nettype none
interface pls_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [pls_pkg::DATA_W-1:0] word_out;
    logic [pls_pkg::POS_W-1:0]  found_position;
    logic [pls_pkg::CNT_W-1:0]  entry_count;

    modport source (output valid, output ok, output word_out, output found_position,
                    output entry_count, input ready);
    modport sink   (input valid, input ok, input word_out, input found_position,
                    input entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/pls_cell.sv =====
`default_nettype none
module pls_cell (
    input  wire logic                           clk,
    input  wire logic [pls_pkg::IDX_W-1:0]      index,
    input  wire pls_pkg::cell_cap_t             cap,
    input  wire pls_pkg::cell_ctl_t             ctl,
    input  wire logic [pls_pkg::WORD_WIDTH-1:0] left_word,
    input  wire logic [pls_pkg::WORD_WIDTH-1:0] right_word,
    output logic      [pls_pkg::WORD_WIDTH-1:0] word,
    output logic                                hit,
    output logic                                sel
);
    import pls_pkg::*;

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  sel_reg;
    logic                  sel_next;

    // A cell matches only while it lies inside the occupied part of the list.
    always_comb
    begin
        hit_next  = (word_reg == cap.value) && (CNT_W'(index) < cap.count);
        sel_next  = (index == cap.target);
        word_next = word_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (index == ctl.k)
                    word_next = ctl.word;
                else if (index > ctl.k)
                    word_next = left_word;
            end
            OP_REMOVE:
            begin
                if (index >= ctl.k)
                    word_next = right_word;
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (cap.capture)
        begin
            hit_reg <= hit_next;
            sel_reg <= sel_next;
        end
    end

    assign word = word_reg;
    assign hit  = hit_reg;
    assign sel  = sel_reg;

endmodule
`default_nettype wire

// ===== rtl/pls_pick.sv =====
`default_nettype none
module pls_pick (
    input  wire logic [pls_pkg::DEPTH-1:0]      hit,
    input  wire logic [pls_pkg::DEPTH-1:0]      sel,
    input  wire logic [pls_pkg::WORD_WIDTH-1:0] words [pls_pkg::DEPTH],
    output logic                                found,
    output logic      [pls_pkg::CNT_W-1:0]      where,
    output logic      [pls_pkg::WORD_WIDTH-1:0] rd_word
);
    import pls_pkg::*;

    // The lowest matching cell wins, so the scan runs from the top down.
    always_comb
    begin
        found   = 1'b0;
        where   = '0;
        rd_word = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found = 1'b1;
                where = CNT_W'(i + 1);
            end
        end
        for (int j = 0; j < DEPTH; j++)
        begin
            rd_word = rd_word | (words[j] & {WORD_WIDTH{sel[j]}});
        end
    end

endmodule
`default_nettype wire

// ===== rtl/positional_list_store.sv =====
`default_nettype none
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   command, position, value
// rsp      out  valid/ready   ok, word_out, found_position, entry_count
//
// At the accepting edge of a request every cell compares its word and flags
// whether it is the addressed entry; in the pick state the priority pick
// resolves those flags and the row of cells shifts in one step.
// The pick cycle waits only while the response register is full and not being
// taken, so a finished response may sit on rsp while the next request comes in.
// Reset clears the entry count and the handshake state; the stored words are
// left as they are, as only positions below the count are ever read.
module positional_list_store (
    input  wire logic clk,
    input  wire logic rst_n,
    pls_req_if.sink   req,
    pls_rsp_if.source rsp
);
    import pls_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    cmd_t                  cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [WORD_WIDTH-1:0] value_reg;
    logic [IDX_W-1:0]      target_reg;
    logic [IDX_W-1:0]      target_next;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic                  rsp_ok_reg;
    logic [DATA_W-1:0]     rsp_word_reg;
    logic [POS_W-1:0]      rsp_pos_reg;
    logic [CNT_W-1:0]      rsp_count_reg;

    logic                  accept;
    logic                  rsp_free;
    logic                  finish;
    cmd_t                  req_cmd;
    cell_cap_t             cap;
    cell_ctl_t             ctl;

    logic [WORD_WIDTH-1:0] words [DEPTH];
    logic [DEPTH-1:0]      hits;
    logic [DEPTH-1:0]      sels;
    logic                  found;
    logic [CNT_W-1:0]      where;
    logic [WORD_WIDTH-1:0] rd_word;

    logic                  full;
    logic                  pos_in;
    logic                  ok;
    logic                  returns_word;

    assign req_cmd  = cmd_t'(req.command);
    assign accept   = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign finish   = (state_reg == ST_PICK) && rsp_free;
    assign req.ready = (state_reg == ST_IDLE);

    // The cell that a request addresses, worked out while the request arrives.
    // Append addresses the first free cell.
    always_comb
    begin
        case (req_cmd)
            CMD_APPEND: target_next = IDX_W'(count_reg);
            CMD_PREV:   target_next = IDX_W'(req.position - POS_W'(2));
            CMD_NEXT:   target_next = IDX_W'(req.position);
            default:    target_next = IDX_W'(req.position - POS_W'(1));
        endcase
    end

    assign cap.capture = accept;
    assign cap.value   = WORD_WIDTH'(req.value);
    assign cap.target  = target_next;
    assign cap.count   = count_reg;

    // Validity of the held request against the current count.
    always_comb
    begin
        full         = (count_reg == CNT_W'(DEPTH));
        pos_in       = (pos_reg >= POS_W'(1)) && (CNT_W'(pos_reg) <= count_reg);
        ok           = 1'b0;
        returns_word = 1'b0;
        count_next   = count_reg;
        case (cmd_reg)
            CMD_INSERT:
            begin
                ok = !full && (pos_reg >= POS_W'(1))
                     && ({1'b0, pos_reg} <= ({1'b0, count_reg} + (CNT_W + 1)'(1)));
                if (ok)
                    count_next = count_reg + CNT_W'(1);
            end
            CMD_APPEND:
            begin
                ok = !full;
                if (ok)
                    count_next = count_reg + CNT_W'(1);
            end
            CMD_REMOVE:
            begin
                ok           = pos_in;
                returns_word = 1'b1;
                if (ok)
                    count_next = count_reg - CNT_W'(1);
            end
            CMD_LOCATE: ok = found;
            CMD_READ:
            begin
                ok           = pos_in;
                returns_word = 1'b1;
            end
            CMD_PREV:
            begin
                ok           = (pos_reg >= POS_W'(2)) && (CNT_W'(pos_reg) <= count_reg);
                returns_word = 1'b1;
            end
            CMD_NEXT:
            begin
                ok           = (pos_reg >= POS_W'(1)) && (CNT_W'(pos_reg) < count_reg);
                returns_word = 1'b1;
            end
            CMD_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            default: ok = 1'b0;
        endcase
    end

    // The row shifts only at the edge that completes a successful request.
    always_comb
    begin
        ctl.op   = OP_HOLD;
        ctl.k    = target_reg;
        ctl.word = value_reg;
        if (finish && ok)
        begin
            if (cmd_reg == CMD_INSERT || cmd_reg == CMD_APPEND)
                ctl.op = OP_INSERT;
            else if (cmd_reg == CMD_REMOVE)
                ctl.op = OP_REMOVE;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] left_w;
        logic [WORD_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = value_reg;
        end
        else
        begin : g_inner_l
            assign left_w = words[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = words[g];
        end
        else
        begin : g_inner_r
            assign right_w = words[g+1];
        end

        pls_cell u_cell (
            .clk        (clk),
            .index      (IDX_W'(g)),
            .cap        (cap),
            .ctl        (ctl),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[g]),
            .hit        (hits[g]),
            .sel        (sels[g])
        );
    end

    pls_pick u_pick (
        .hit     (hits),
        .sel     (sels),
        .words   (words),
        .found   (found),
        .where   (where),
        .rd_word (rd_word)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (rsp_free)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (finish)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req_cmd;
            pos_reg    <= req.position;
            value_reg  <= WORD_WIDTH'(req.value);
            target_reg <= target_next;
        end
        if (finish)
        begin
            rsp_ok_reg    <= ok;
            rsp_word_reg  <= (ok && returns_word) ? DATA_W'(rd_word) : '0;
            rsp_pos_reg   <= (ok && cmd_reg == CMD_LOCATE) ? POS_W'(where) : '0;
            rsp_count_reg <= count_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.ok             = rsp_ok_reg;
    assign rsp.word_out       = rsp_word_reg;
    assign rsp.found_position = rsp_pos_reg;
    assign rsp.entry_count    = rsp_count_reg;

    // The list never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A request taken is always followed by the pick cycle.
    a_accept_pick: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_PICK))
        else $error("pick cycle missing after request");

    // The count only moves on the edge that completes a request.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(count_reg))
        else $error("count changed outside a pick cycle");

    // A failed request carries no word and no position.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ok_reg) |-> (rsp_word_reg == '0 && rsp_pos_reg == '0))
        else $error("failed response carries data");

    // The shift happens only when a response is written.
    a_shift_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op != OP_HOLD) |=> rsp_valid_reg)
        else $error("row shifted without a response");

endmodule
`default_nettype wire

// ===== test/tb_positional_list_store.sv =====
`timescale 1ns / 100ps

module tb_positional_list_store;

    import pls_pkg::*;

    // A request that waits this many cycles with nothing moving on either
    // channel means the block has hung. The longest legitimate quiet stretch
    // is the deliberate response hold-off plus one sender gap, which is far
    // below this.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS = 100;

    // What one response should carry.
    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] word;
        logic [POS_W-1:0]  where;
        logic [CNT_W-1:0]  held;
    } list_answer_t;

    logic clk;
    logic rst_n;

    pls_req_if req_bus();
    pls_rsp_if rsp_bus();

    positional_list_store u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // Shadow of the list contents, in position order; its size is the count.
    logic [DATA_W-1:0] list_words[$];
    // Answers owed by the block, oldest first.
    list_answer_t      answers_due[$];

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int hold_cycles = 0;
    bit sender_gaps = 1'b1;
    bit sink_stalls = 1'b1;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one request to the shadow list and returns the answer that the
    // block must give for it. Called at the edge where the request is taken,
    // so the shadow always reflects every request accepted so far.
    function automatic list_answer_t list_apply(cmd_t op, logic [POS_W-1:0] pos,
                                                logic [DATA_W-1:0] word);
        list_answer_t ans;
        int p;
        int n;
        p = int'(pos);
        n = list_words.size();
        ans.ok = 1'b0;
        ans.word = '0;
        ans.where = '0;
        case (op)
            CMD_INSERT:
            begin
                // Insertion is allowed anywhere from the head to just past
                // the tail, and only while there is room.
                if (n < DEPTH && p >= 1 && p <= n + 1)
                begin
                    list_words.insert(p - 1, word);
                    ans.ok = 1'b1;
                end
            end
            CMD_APPEND:
            begin
                if (n < DEPTH)
                begin
                    list_words.push_back(word);
                    ans.ok = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (p >= 1 && p <= n)
                begin
                    ans.word = list_words[p - 1];
                    list_words.delete(p - 1);
                    ans.ok = 1'b1;
                end
            end
            CMD_LOCATE:
            begin
                // The first match wins, so duplicates report the lowest position.
                for (int i = 0; i < n; i++)
                begin
                    if (!ans.ok && list_words[i] == word)
                    begin
                        ans.ok = 1'b1;
                        ans.where = POS_W'(i + 1);
                    end
                end
            end
            CMD_READ:
            begin
                if (p >= 1 && p <= n)
                begin
                    ans.word = list_words[p - 1];
                    ans.ok = 1'b1;
                end
            end
            CMD_PREV:
            begin
                if (p >= 2 && p <= n)
                begin
                    ans.word = list_words[p - 2];
                    ans.ok = 1'b1;
                end
            end
            CMD_NEXT:
            begin
                if (p >= 1 && p + 1 <= n)
                begin
                    ans.word = list_words[p];
                    ans.ok = 1'b1;
                end
            end
            default:
            begin
                list_words.delete();
                ans.ok = 1'b1;
            end
        endcase
        ans.held = CNT_W'(list_words.size());
        return ans;
    endfunction

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high on return; the next call either replaces the payload in the
    // same step or drops valid for a gap, so valid never sees two updates in
    // one time step.
    task automatic send_request(cmd_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] word);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.command  <= op;
        req_bus.position <= pos;
        req_bus.value    <= word;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        answers_due.push_back(list_apply(op, pos, word));
    endtask

    // Withdraws the request and waits until every owed answer has come back.
    task automatic wait_for_answers();
        req_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (answers_due.size() != 0);
    endtask

    // Words are drawn from a handful of small values often enough that
    // duplicates appear and locate has several candidates to choose between.
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DATA_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // Positions are mostly legal for the command at the current list size,
    // with one in ten drawn from zero up to the depth to hit the refusals.
    function automatic logic [POS_W-1:0] pick_position(cmd_t op);
        int n;
        n = list_words.size();
        if ($urandom_range(0, 9) == 0)
        begin
            return POS_W'($urandom_range(0, DEPTH));
        end
        case (op)
            CMD_INSERT:
                return POS_W'($urandom_range(1, n + 1));
            CMD_REMOVE, CMD_READ:
                return (n == 0) ? POS_W'($urandom_range(0, 2)) : POS_W'($urandom_range(1, n));
            CMD_PREV:
                return (n < 2) ? POS_W'($urandom_range(0, 3)) : POS_W'($urandom_range(2, n));
            CMD_NEXT:
                return (n < 2) ? POS_W'($urandom_range(0, 3))
                               : POS_W'($urandom_range(1, n - 1));
            default:
                return POS_W'($urandom_range(0, DEPTH));
        endcase
    endfunction

    // Empty-list refusals, every command once or more, the field extremes and
    // each boundary of the position checks on a short list.
    task automatic test_directed_commands();
        send_request(CMD_CLEAR, '0, '0);
        send_request(CMD_READ, 7'd1, '0);
        send_request(CMD_REMOVE, 7'd1, '0);
        send_request(CMD_LOCATE, '0, '0);
        send_request(CMD_INSERT, 7'd0, 32'h0000_00AA);
        send_request(CMD_INSERT, 7'd2, 32'h0000_00BB);
        send_request(CMD_INSERT, 7'd1, 32'h0000_0000);
        send_request(CMD_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 7'd2, 32'hA5A5_5A5A);
        send_request(CMD_INSERT, 7'd4, 32'h0000_0001);
        send_request(CMD_INSERT, 7'd64, 32'h1234_5678);
        send_request(CMD_LOCATE, 7'd0, 32'hFFFF_FFFF);
        send_request(CMD_LOCATE, 7'd0, 32'h0000_1234);
        // A second zero word: locate must still report the first one.
        send_request(CMD_APPEND, 7'd0, 32'h0000_0000);
        send_request(CMD_LOCATE, 7'd0, 32'h0000_0000);
        send_request(CMD_READ, 7'd0, '0);
        send_request(CMD_READ, 7'd5, '0);
        send_request(CMD_READ, 7'd6, '0);
        send_request(CMD_PREV, 7'd1, '0);
        send_request(CMD_PREV, 7'd2, '0);
        send_request(CMD_NEXT, 7'd5, '0);
        send_request(CMD_NEXT, 7'd1, '0);
        send_request(CMD_REMOVE, 7'd0, '0);
        send_request(CMD_REMOVE, 7'd2, '0);
        send_request(CMD_REMOVE, 7'd4, '0);
        send_request(CMD_REMOVE, 7'd9, '0);
        send_request(CMD_CLEAR, '0, '0);
        wait_for_answers();
    endtask

    // Fills the list to the top while the response side is held off, so the
    // block backs up and stops taking further requests for a long stretch. Then the
    // full-list refusals and the reads at the last position.
    task automatic test_full_list_under_backpressure();
        send_request(CMD_CLEAR, '0, '0);
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (DEPTH)
        begin
            send_request(CMD_APPEND, POS_W'($urandom_range(0, DEPTH)), rand_word());
        end
        send_request(CMD_APPEND, '0, 32'hDEAD_BEEF);
        send_request(CMD_INSERT, 7'd1, 32'hDEAD_BEEF);
        send_request(CMD_INSERT, POS_W'(DEPTH), 32'hDEAD_BEEF);
        send_request(CMD_READ, POS_W'(DEPTH), '0);
        send_request(CMD_PREV, POS_W'(DEPTH), '0);
        send_request(CMD_NEXT, POS_W'(DEPTH - 1), '0);
        send_request(CMD_NEXT, POS_W'(DEPTH), '0);
        send_request(CMD_LOCATE, '0, list_words[DEPTH - 1]);
        send_request(CMD_REMOVE, POS_W'(DEPTH), '0);
        send_request(CMD_INSERT, POS_W'(DEPTH), rand_word());
        send_request(CMD_REMOVE, 7'd1, '0);
        wait_for_answers();
    endtask

    // Random traffic that drifts the list between empty and full: a growing
    // phase favours insert and append, a shrinking one favours remove. A few
    // requests per hundred are pure noise: any command, any word and a position up to the depth.
    task automatic test_random_traffic(int requests);
        bit growing;
        int roll;
        int n;
        cmd_t op;
        logic [POS_W-1:0] pos;
        logic [DATA_W-1:0] word;
        growing = 1'b1;
        repeat (requests)
        begin
            n = list_words.size();
            if (n == DEPTH)
            begin
                growing = 1'b0;
            end
            else if (n == 0)
            begin
                growing = 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                growing = !growing;
            end
            roll = $urandom_range(0, 99);
            if (roll < 1)
                op = CMD_CLEAR;
            else if (roll < (growing ? 36 : 11))
                op = CMD_INSERT;
            else if (roll < (growing ? 56 : 16))
                op = CMD_APPEND;
            else if (roll < (growing ? 64 : 51))
                op = CMD_REMOVE;
            else if (roll < (growing ? 74 : 66))
                op = CMD_LOCATE;
            else if (roll < (growing ? 84 : 80))
                op = CMD_READ;
            else if (roll < (growing ? 90 : 88))
                op = CMD_PREV;
            else if (roll < 96)
                op = CMD_NEXT;
            else
                op = cmd_t'($urandom_range(0, 7));
            if (roll >= 96)
            begin
                pos = POS_W'($urandom_range(0, DEPTH));
                word = $urandom();
            end
            else
            begin
                pos = pick_position(op);
                // Locate mostly looks for a word that is present.
                if (op == CMD_LOCATE && n > 0 && $urandom_range(0, 9) < 6)
                    word = list_words[$urandom_range(0, n - 1)];
                else
                    word = rand_word();
            end
            send_request(op, pos, word);
        end
    endtask

    // Random traffic in segments, with idling on either side switched on or
    // off per segment so that quiet and busy stretches both occur.
    task automatic test_random_with_idling();
        for (int seg = 0; seg < 13; seg++)
        begin
            sender_gaps = 1'($urandom_range(0, 1));
            sink_stalls = 1'($urandom_range(0, 1));
            test_random_traffic(50);
        end
        wait_for_answers();
    endtask

    // Closing stretch with both sides at full rate.
    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_traffic(100);
        wait_for_answers();
    endtask

    task automatic report_field(string field, logic [DATA_W-1:0] expected_v,
                                logic [DATA_W-1:0] actual_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, expected_v, actual_v);
        end
    endtask

    // Response side pacing. Ready is held low for occasional bursts, and for
    // one long stretch when the stimulus asks for it; that stretch is counted
    // here so that the sender keeps offering requests meanwhile.
    initial
    begin : sink_pacing
        int stall;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else if (sink_stalls && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 18);
            end
            else
            begin
                stall = 0;
            end
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Every response taken is checked against the oldest answer owed.
    always @(posedge clk)
    begin : answer_check
        list_answer_t due;
        if (rsp_bus.valid && rsp_bus.ready)
        begin
            if (answers_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: response with no request outstanding, expected none, actual %0h",
                         $time, rsp_bus.word_out);
            end
            else
            begin
                due = answers_due.pop_front();
                if (rsp_bus.ok !== due.ok)
                    report_field("ok", DATA_W'(due.ok), DATA_W'(rsp_bus.ok));
                if (rsp_bus.word_out !== due.word)
                    report_field("word_out", due.word, rsp_bus.word_out);
                if (rsp_bus.found_position !== due.where)
                    report_field("found_position", DATA_W'(due.where),
                                 DATA_W'(rsp_bus.found_position));
                if (rsp_bus.entry_count !== due.held)
                    report_field("entry_count", DATA_W'(due.held),
                                 DATA_W'(rsp_bus.entry_count));
            end
        end
    end

    // Ends the run if neither channel has moved for too long.
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.command  <= CMD_CLEAR;
        req_bus.position <= '0;
        req_bus.value    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_commands();
        test_full_list_under_backpressure();
        test_random_with_idling();
        test_back_to_back();

        // Anything arriving in this pause has no request behind it.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && answers_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pls_pkg.sv
rtl/pls_req_if.sv
rtl/pls_rsp_if.sv
rtl/pls_cell.sv
rtl/pls_pick.sv
rtl/positional_list_store.sv
test/tb_positional_list_store.sv
